@@ hw/rtl/bai_pkg.sv @@
package bai_pkg;

    // pool geometry
    localparam int MAX_IDS   = 1024;
    localparam int WORD_BITS = 64;
    localparam int NWORDS    = (MAX_IDS + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W    = $clog2(NWORDS);
    localparam int OFF_W     = $clog2(WORD_BITS);
    localparam int SCAN_W    = $clog2(NWORDS + 1);

    // field widths
    localparam int ID_W  = 10;
    localparam int CNT_W = 11;
    localparam int LIM_W = 11;

    localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(MAX_IDS);
    localparam logic [LIM_W-1:0] LIM_MAX   = LIM_W'(MAX_IDS);
    localparam logic [CNT_W-1:0] CNT_MAX   = '1;

    typedef enum logic [1:0] {
        MODE_ALLOC_LO = 2'd0,
        MODE_ALLOC_HI = 2'd1,
        MODE_FREE     = 2'd2,
        MODE_QUERY    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_EXHAUSTED    = 2'd1,
        ST_OUT_OF_RANGE = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic    load;
        logic    scan_rd;
        logic    req_rd;
        logic    commit_alloc;
        logic    commit_free;
        logic    report;
        status_t rpt_status;
        logic    rpt_qfree;
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        mode_t mode;
        logic  req_oor;
        logic  pend;
        logic  hit;
        logic  scan_done;
        logic  bit_free;
        logic  out_free;
    } ctl_stat_t;

    // offset (from msb) of the first set bit seen from the msb side
    function automatic logic [OFF_W-1:0] lead_offset(input logic [WORD_BITS-1:0] w);
        logic [OFF_W-1:0] off;
        off = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (w[b])
            begin
                off = OFF_W'(WORD_BITS - 1 - b);
            end
        end
        return off;
    endfunction

    // offset (from msb) of the first set bit seen from the lsb side
    function automatic logic [OFF_W-1:0] trail_offset(input logic [WORD_BITS-1:0] w);
        logic [OFF_W-1:0] off;
        off = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (w[b])
            begin
                off = OFF_W'(WORD_BITS - 1 - b);
            end
        end
        return off;
    endfunction

    // bits of word idx whose ids sit below lim
    function automatic logic [WORD_BITS-1:0] word_mask(input logic [LIM_W-1:0]  lim,
                                                       input logic [WIDX_W-1:0] idx);
        logic [LIM_W-OFF_W-1:0] full;
        logic [OFF_W-1:0]       part;
        logic [LIM_W-OFF_W-1:0] idx_x;
        logic [WORD_BITS-1:0]   m;
        full  = lim[LIM_W-1:OFF_W];
        part  = lim[OFF_W-1:0];
        idx_x = (LIM_W-OFF_W)'(idx);
        if (idx_x < full)
        begin
            m = '1;
        end
        else if (idx_x == full)
        begin
            m = ~({WORD_BITS{1'b1}} >> part);
        end
        else
        begin
            m = '0;
        end
        return m;
    endfunction

endpackage

@@ hw/rtl/bai_datapath.sv @@
module bai_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [bai_pkg::LIM_W-1:0]     cfg_data,
    input  logic [1:0]                    mode,
    input  logic [bai_pkg::ID_W-1:0]      request_id,
    input  bai_pkg::ctl_cmd_t             cmd,
    output bai_pkg::ctl_stat_t            st,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bai_pkg::ID_W-1:0]      result_id,
    output logic [1:0]                    status,
    output logic                          id_is_free,
    output logic [bai_pkg::CNT_W-1:0]     in_use_count
);

    localparam int WB = bai_pkg::WORD_BITS;
    localparam int WI = bai_pkg::WIDX_W;
    localparam int OW = bai_pkg::OFF_W;

    // bitmap storage, invalid entries read as all free
    logic [WB-1:0] mem [bai_pkg::NWORDS];
    logic [bai_pkg::NWORDS-1:0] vld_reg;
    logic [WB-1:0] mem_q_reg;
    logic          vld_q_reg;

    logic [bai_pkg::LIM_W-1:0]  id_limit_reg;
    bai_pkg::mode_t             mode_reg;
    logic [bai_pkg::ID_W-1:0]   req_reg;
    logic [bai_pkg::LIM_W-1:0]  lim_reg;
    logic [WI-1:0]              scan_idx_reg;
    logic [bai_pkg::SCAN_W-1:0] remain_reg;
    logic                       pend_reg;
    logic [WI-1:0]              rd_idx_reg;
    logic [bai_pkg::CNT_W-1:0]  used_count_reg;

    logic                       out_valid_reg;
    logic [bai_pkg::ID_W-1:0]   result_id_reg;
    bai_pkg::status_t           status_reg;
    logic                       id_is_free_reg;
    logic [bai_pkg::CNT_W-1:0]  in_use_count_reg;

    logic [bai_pkg::LIM_W-1:0]  lim_in;
    logic [bai_pkg::LIM_W:0]    lim_round;
    logic [bai_pkg::SCAN_W-1:0] nwords_in;
    logic [WI-1:0]              last_word;
    logic                       rd_en;
    logic [WI-1:0]              rd_addr;
    logic [WB-1:0]              rd_word;
    logic [WB-1:0]              masked;
    logic [OW-1:0]              alloc_off;
    logic [OW-1:0]              req_off;
    logic [WB-1:0]              alloc_bit;
    logic [WB-1:0]              req_bit;
    logic                       wr_en;
    logic [WB-1:0]              wr_data;
    logic                       out_free;
    logic                       is_alloc;
    logic [bai_pkg::CNT_W-1:0]  cnt_inc;
    logic [bai_pkg::CNT_W-1:0]  cnt_dec;

    function automatic logic cfg_limit_gt();
        return id_limit_reg > bai_pkg::LIM_MAX;
    endfunction

    // limit saturated to pool size, and the number of words it covers
    assign lim_in    = (cfg_limit_gt()) ? bai_pkg::LIM_MAX : id_limit_reg;
    assign lim_round = {1'b0, lim_in} + (bai_pkg::LIM_W + 1)'(WB - 1);
    assign nwords_in = bai_pkg::SCAN_W'(lim_round >> OW);
    assign last_word = WI'(nwords_in - 1'b1);

    assign rd_en   = cmd.scan_rd | cmd.req_rd;
    assign rd_addr = cmd.req_rd ? req_reg[bai_pkg::ID_W-1:OW] : scan_idx_reg;
    assign rd_word = vld_q_reg ? mem_q_reg : '1;
    assign masked  = rd_word & bai_pkg::word_mask(lim_reg, rd_idx_reg);

    assign alloc_off = (mode_reg == bai_pkg::MODE_ALLOC_HI) ? bai_pkg::trail_offset(masked)
                                                            : bai_pkg::lead_offset(masked);
    assign req_off   = req_reg[OW-1:0];
    assign alloc_bit = {{(WB-1){1'b0}}, 1'b1} << (OW'(WB - 1) - alloc_off);
    assign req_bit   = {{(WB-1){1'b0}}, 1'b1} << (OW'(WB - 1) - req_off);

    assign wr_en   = cmd.commit_alloc | cmd.commit_free;
    assign wr_data = cmd.commit_alloc ? (rd_word & ~alloc_bit) : (rd_word | req_bit);

    assign out_free = !out_valid_reg || !out_stall;
    assign is_alloc = (mode_reg == bai_pkg::MODE_ALLOC_LO) || (mode_reg == bai_pkg::MODE_ALLOC_HI);
    assign cnt_inc  = (used_count_reg == bai_pkg::CNT_MAX) ? used_count_reg
                                                           : used_count_reg + 1'b1;
    assign cnt_dec  = (used_count_reg == '0) ? used_count_reg : used_count_reg - 1'b1;

    always_comb
    begin
        st.mode      = mode_reg;
        st.req_oor   = {1'b0, req_reg} >= lim_reg;
        st.pend      = pend_reg;
        st.hit       = |masked;
        st.scan_done = (remain_reg == '0);
        st.bit_free  = |(rd_word & req_bit);
        st.out_free  = out_free;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[rd_idx_reg] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
        if (cmd.load)
        begin
            req_reg <= request_id;
        end
        if (cmd.commit_alloc)
        begin
            result_id_reg <= {rd_idx_reg, alloc_off};
        end
        else if (cmd.report)
        begin
            result_id_reg <= is_alloc ? '0 : req_reg;
        end
        else if (cmd.commit_free)
        begin
            result_id_reg <= req_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg          <= '0;
            vld_q_reg        <= 1'b0;
            id_limit_reg     <= bai_pkg::LIM_RESET;
            mode_reg         <= bai_pkg::MODE_ALLOC_LO;
            lim_reg          <= '0;
            scan_idx_reg     <= '0;
            remain_reg       <= '0;
            pend_reg         <= 1'b0;
            rd_idx_reg       <= '0;
            used_count_reg   <= '0;
            out_valid_reg    <= 1'b0;
            status_reg       <= bai_pkg::ST_OK;
            id_is_free_reg   <= 1'b0;
            in_use_count_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                id_limit_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                mode_reg     <= bai_pkg::mode_t'(mode);
                lim_reg      <= lim_in;
                remain_reg   <= nwords_in;
                scan_idx_reg <= (bai_pkg::mode_t'(mode) == bai_pkg::MODE_ALLOC_HI) ? last_word
                                                                                   : '0;
                pend_reg     <= 1'b0;
            end
            else if (cmd.scan_rd)
            begin
                scan_idx_reg <= (mode_reg == bai_pkg::MODE_ALLOC_HI) ? scan_idx_reg - 1'b1
                                                                     : scan_idx_reg + 1'b1;
                remain_reg   <= remain_reg - 1'b1;
                pend_reg     <= 1'b1;
            end
            if (rd_en)
            begin
                vld_q_reg  <= vld_reg[rd_addr];
                rd_idx_reg <= rd_addr;
            end
            if (wr_en)
            begin
                vld_reg[rd_idx_reg] <= 1'b1;
            end
            if (cmd.commit_alloc)
            begin
                used_count_reg <= cnt_inc;
            end
            else if (cmd.commit_free)
            begin
                used_count_reg <= cnt_dec;
            end

            if (cmd.commit_alloc || cmd.commit_free || cmd.report)
            begin
                out_valid_reg    <= 1'b1;
                status_reg       <= cmd.report ? cmd.rpt_status : bai_pkg::ST_OK;
                id_is_free_reg   <= cmd.report & cmd.rpt_qfree;
                in_use_count_reg <= cmd.commit_alloc ? cnt_inc
                                  : cmd.commit_free  ? cnt_dec
                                  : used_count_reg;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_id    = result_id_reg;
    assign status       = status_reg;
    assign id_is_free   = id_is_free_reg;
    assign in_use_count = in_use_count_reg;

endmodule

@@ hw/rtl/bai_ctrl.sv @@
module bai_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  bai_pkg::ctl_stat_t st,
    output bai_pkg::ctl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_ALLOC,
        S_LOOK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (st.mode inside {bai_pkg::MODE_ALLOC_LO, bai_pkg::MODE_ALLOC_HI})
                begin
                    state_next = S_SCAN;
                end
                else if (st.req_oor)
                begin
                    if (st.out_free)
                    begin
                        cmd.report     = 1'b1;
                        cmd.rpt_status = bai_pkg::ST_OUT_OF_RANGE;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    cmd.req_rd = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_SCAN:
            begin
                if (st.pend && st.hit)
                begin
                    state_next = S_ALLOC;
                end
                else if (!st.scan_done)
                begin
                    cmd.scan_rd = 1'b1;
                end
                else if (st.out_free)
                begin
                    cmd.report     = 1'b1;
                    cmd.rpt_status = bai_pkg::ST_EXHAUSTED;
                    state_next     = S_IDLE;
                end
            end
            S_ALLOC:
            begin
                if (st.out_free)
                begin
                    cmd.commit_alloc = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_LOOK:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                    if (st.mode == bai_pkg::MODE_QUERY)
                    begin
                        cmd.report     = 1'b1;
                        cmd.rpt_status = bai_pkg::ST_OK;
                        cmd.rpt_qfree  = st.bit_free;
                    end
                    else if (st.bit_free)
                    begin
                        cmd.report     = 1'b1;
                        cmd.rpt_status = bai_pkg::ST_ALREADY_FREE;
                    end
                    else
                    begin
                        cmd.commit_free = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign in_stall = busy_reg;

endmodule

@@ hw/rtl/bitmap_id_allocator.sv @@
// Identifier pool allocator over 1024 ids, kept as sixteen 64-bit bitmap words
// (set bit = free, lowest id of a word at its msb; the pool resets to all free
// and zero in use). Each input word carries a mode: allocate the lowest or
// highest free id below id_limit, free request_id, or query it. Each
// input word gives exactly one output word with result_id, status, the query
// answer and the in-use count after the step. One request is worked at a time.
// A free or query reads the bitmap word of request_id, then writes its output
// word; an id out of range is answered without the read. The next input word
// is taken once the output word is written. Allocation scans the bitmap words
// one per cycle through a single registered read port and stops at the first
// word that holds a free id, or reports exhausted once all words covered by the
// limit (up to 16) are read. A waiting output word does not hold off acceptance
// of the next input word; that word's result waits until the output register
// frees. id_limit is written through cfg_write / cfg_data and should only change
// while the block is idle.
module bitmap_id_allocator (
    input  logic                          clk,
    input  logic                          rst_n,

    // configuration: id_limit
    input  logic                          cfg_write,
    input  logic [bai_pkg::LIM_W-1:0]     cfg_data,

    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    mode,
    input  logic [bai_pkg::ID_W-1:0]      request_id,

    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bai_pkg::ID_W-1:0]      result_id,
    output logic [1:0]                    status,
    output logic                          id_is_free,
    output logic [bai_pkg::CNT_W-1:0]     in_use_count
);

    // command and status between sequencer and bitmap datapath
    bai_pkg::ctl_cmd_t  cmd;
    bai_pkg::ctl_stat_t st;

    // sequencer: request decode, word scan, write-back and result timing
    bai_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // bitmap words, limit register, in-use counter and output word register
    bai_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .mode         (mode),
        .request_id   (request_id),
        .cmd          (cmd),
        .st           (st),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_id    (result_id),
        .status       (status),
        .id_is_free   (id_is_free),
        .in_use_count (in_use_count)
    );

endmodule

@@ hw/rtl/bai_checker.sv @@
module bai_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [bai_pkg::ID_W-1:0]  result_id,
    input logic [1:0]                status,
    input logic                      id_is_free,
    input logic [bai_pkg::CNT_W-1:0] in_use_count
);

    // a stalled output word stays
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    // exhausted reports id zero and no query answer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == bai_pkg::ST_EXHAUSTED) |-> (result_id == '0) && !id_is_free)
        else $error("exhausted word carries an id");

    // a free answer only comes with ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && id_is_free |-> (status == bai_pkg::ST_OK))
        else $error("free answer with error status");

    // never more ids in use than the pool holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (in_use_count <= bai_pkg::CNT_W'(bai_pkg::MAX_IDS)))
        else $error("in-use count beyond pool size");

endmodule

bind bitmap_id_allocator bai_checker u_bai_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_id    (result_id),
    .status       (status),
    .id_is_free   (id_is_free),
    .in_use_count (in_use_count)
);

@@ verif/id_pool_checker.sv @@
module id_pool_checker
    import bai_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [LIM_W-1:0] cfg_data,
    input  logic             in_valid,
    input  logic             in_stall,
    input  logic [1:0]       mode,
    input  logic [ID_W-1:0]  request_id,
    input  logic             out_valid,
    input  logic             out_stall,
    input  logic [ID_W-1:0]  result_id,
    input  logic [1:0]       status,
    input  logic             id_is_free,
    input  logic [CNT_W-1:0] in_use_count,
    output int               mismatch_count,
    output int               results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [ID_W-1:0]  rid;
        status_t          st;
        logic             qfree;
        logic [CNT_W-1:0] count;
    } pool_result_t;

    // one bit per id, set means free
    logic [MAX_IDS-1:0] free_ids;
    logic [CNT_W-1:0]   used_ids;
    logic [LIM_W-1:0]   id_limit;
    pool_result_t       owed_results[$];

    task automatic serve_request(input mode_t m, input logic [ID_W-1:0] req,
                                 output pool_result_t r);
        int usable;
        int id;
        usable  = (id_limit > LIM_MAX) ? MAX_IDS : int'(id_limit);
        r.rid   = '0;
        r.st    = ST_OK;
        r.qfree = 1'b0;
        case (m)
            MODE_ALLOC_LO, MODE_ALLOC_HI:
            begin
                r.st = ST_EXHAUSTED;
                for (int i = 0; i < usable; i++)
                begin
                    id = (m == MODE_ALLOC_LO) ? i : usable - 1 - i;
                    if (free_ids[id])
                    begin
                        free_ids[id] = 1'b0;
                        if (used_ids != CNT_MAX)
                        begin
                            used_ids = used_ids + 1'b1;
                        end
                        r.rid = ID_W'(id);
                        r.st  = ST_OK;
                        break;
                    end
                end
            end
            MODE_FREE:
            begin
                r.rid = req;
                if (int'(req) >= usable)
                begin
                    r.st = ST_OUT_OF_RANGE;
                end
                else if (free_ids[req])
                begin
                    r.st = ST_ALREADY_FREE;
                end
                else
                begin
                    free_ids[req] = 1'b1;
                    if (used_ids != '0)
                    begin
                        used_ids = used_ids - 1'b1;
                    end
                end
            end
            default:
            begin
                r.rid = req;
                if (int'(req) >= usable)
                begin
                    r.st = ST_OUT_OF_RANGE;
                end
                else
                begin
                    r.qfree = free_ids[req];
                end
            end
        endcase
        r.count = used_ids;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pool_result_t r;
        if (!rst_n)
        begin
            free_ids       = '1;
            used_ids       = '0;
            id_limit       = LIM_RESET;
            mismatch_count = 0;
            owed_results.delete();
            results_owed  <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                id_limit = cfg_data;
            end
            // results first, so a new request never answers an old word
            if (out_valid && !out_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    $error("result word with nothing expected: result_id %0d", result_id);
                    mismatch_count++;
                end
                else
                begin
                    r = owed_results.pop_front();
                    check_field("result_id", 16'(r.rid), 16'(result_id));
                    check_field("status", 16'(r.st), 16'(status));
                    check_field("id_is_free", 16'(r.qfree), 16'(id_is_free));
                    check_field("in_use_count", 16'(r.count), 16'(in_use_count));
                end
            end
            if (in_valid && !in_stall)
            begin
                serve_request(mode_t'(mode), request_id, r);
                owed_results.push_back(r);
            end
            results_owed <= owed_results.size();
        end
    end

endmodule

@@ verif/tb_bitmap_id_allocator.sv @@
module tb_bitmap_id_allocator;
    import bai_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // generous bound for ~670 request words
    localparam int CYCLE_LIMIT  = 400000;
    // longest allocation scan plus output register, with margin
    localparam int DRAIN_CYCLES = 24;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             cfg_write  = 1'b0;
    logic [LIM_W-1:0] cfg_data   = '0;
    logic             in_valid   = 1'b0;
    logic             in_stall;
    logic [1:0]       mode       = MODE_QUERY;
    logic [ID_W-1:0]  request_id = '0;
    logic             out_valid;
    logic             out_stall  = 1'b0;
    logic [ID_W-1:0]  result_id;
    logic [1:0]       status;
    logic             id_is_free;
    logic [CNT_W-1:0] in_use_count;

    int mismatch_count;
    int results_owed;
    int cycle_count   = 0;
    int send_idle_pct = 35;
    int recv_idle_pct = 45;

    bitmap_id_allocator u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .request_id   (request_id),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_id    (result_id),
        .status       (status),
        .id_is_free   (id_is_free),
        .in_use_count (in_use_count)
    );

    id_pool_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .request_id     (request_id),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_id      (result_id),
        .status         (status),
        .id_is_free     (id_is_free),
        .in_use_count   (in_use_count),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    always #2 clk = ~clk;

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // hard stop if the run hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // present one request word and hold it until taken
    task automatic push_request(input mode_t m, input logic [ID_W-1:0] id);
        // random gap with valid low
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        request_id <= id;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // sender holds off until every result word is back, then writes id_limit
    task automatic set_limit(input int lim);
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= LIM_W'(lim);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // ids mostly near the two ends the allocator hands out from
    function automatic logic [ID_W-1:0] pick_id(input int usable);
        int sel;
        int span;
        sel  = $urandom_range(0, 3);
        span = (usable < 48) ? usable : 48;
        if (usable == 0 || sel == 3)
        begin
            return ID_W'($urandom_range(0, MAX_IDS - 1));
        end
        if (sel == 2)
        begin
            return ID_W'(usable - 1 - $urandom_range(0, span - 1));
        end
        return ID_W'($urandom_range(0, span - 1));
    endfunction

    task automatic run_phase(input int lim, input int n, input int alloc_pct);
        int    usable;
        int    pick;
        int    k;
        mode_t m;
        set_limit(lim);
        usable = (lim > MAX_IDS) ? MAX_IDS : lim;
        for (k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < alloc_pct)
            begin
                m = $urandom_range(0, 1) ? MODE_ALLOC_HI : MODE_ALLOC_LO;
            end
            else if (pick < alloc_pct + (100 - alloc_pct) * 2 / 3)
            begin
                m = MODE_FREE;
            end
            else
            begin
                m = MODE_QUERY;
            end
            push_request(m, pick_id(usable));
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limit: both ends, free twice, query both states
        push_request(MODE_ALLOC_LO, 10'h3ff);
        push_request(MODE_ALLOC_HI, 10'h000);
        push_request(MODE_QUERY, 10'd0);
        push_request(MODE_QUERY, 10'd5);
        push_request(MODE_FREE, 10'd1023);
        push_request(MODE_FREE, 10'd1023);
        push_request(MODE_FREE, 10'd0);
        push_request(MODE_QUERY, 10'd1023);

        // limit zero: nothing usable
        set_limit(0);
        push_request(MODE_ALLOC_LO, 10'd0);
        push_request(MODE_ALLOC_HI, 10'd0);
        push_request(MODE_FREE, 10'd0);
        push_request(MODE_QUERY, 10'd0);

        // limit above the pool size saturates
        set_limit(2047);
        push_request(MODE_ALLOC_HI, 10'h155);
        push_request(MODE_FREE, 10'd1023);

        // single id: fill, exhaust, out of range just above
        set_limit(1);
        push_request(MODE_ALLOC_LO, 10'h2aa);
        push_request(MODE_ALLOC_LO, 10'd0);
        push_request(MODE_ALLOC_HI, 10'd0);
        push_request(MODE_QUERY, 10'd1);
        push_request(MODE_FREE, 10'd1);
        push_request(MODE_FREE, 10'd0);

        // limit one past a word boundary
        set_limit(65);
        push_request(MODE_ALLOC_HI, 10'd0);
        push_request(MODE_QUERY, 10'd64);
        push_request(MODE_FREE, 10'd64);

        // random traffic, sender-light / receiver-heavy idling
        run_phase(1024, 120, 60);
        run_phase(130, 150, 85);

        // swap the idling mix
        send_idle_pct = 45;
        recv_idle_pct = 35;
        run_phase(2047, 100, 40);
        run_phase(64, 100, 55);

        // full rate both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(65, 60, 50);
        run_phase($urandom_range(1, MAX_IDS - 1), 120, 50);

        // drain
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
